[src/hrd_pkg.sv]
package hrd_pkg;

  // image geometry
  localparam int unsigned WIDTH  = 64;
  localparam int unsigned HEIGHT = 64;
  localparam int unsigned NPIX   = WIDTH * HEIGHT;
  localparam int unsigned ADDR_W = $clog2(NPIX);
  localparam int unsigned ROW_W  = (HEIGHT > 2) ? $clog2(HEIGHT) : 1;
  localparam int unsigned COL_W  = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  // number formats
  localparam int unsigned Q_W    = 24;   // stored signed q8.16
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned PROD_W = 48;   // product and accumulator width
  localparam int unsigned MUL_W  = 32;   // multiplier operand width
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // iterative units
  localparam int unsigned SQ_STEPS  = PROD_W / 2;
  localparam int unsigned SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int unsigned DIV_NUM_W = 40;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic signed [PROD_W-1:0] Q_ONE  = 48'sd65536;
  localparam logic signed [PROD_W-1:0] Q_HALF = 48'sd32768;
  localparam logic signed [PROD_W-1:0] Q_MAX  = 48'sd8388607;
  localparam logic signed [PROD_W-1:0] Q_MIN  = -48'sd8388608;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STEPS    = 3'd0,
    CFG_TAU          = 3'd1,
    CFG_SIGMA        = 3'd2,
    CFG_THETA        = 3'd3,
    CFG_DUAL_SCALE   = 3'd4,
    CFG_TAU_GAMMA    = 3'd5,
    CFG_PRIMAL_SCALE = 3'd6
  } cfg_idx_t;

  // q.16 product rounded to nearest, ties upward
  function automatic logic signed [PROD_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
    return (v + Q_HALF) >>> 16;
  endfunction

  function automatic logic signed [Q_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) r = Q_MAX[Q_W-1:0];
    else if (v < Q_MIN) r = Q_MIN[Q_W-1:0];
    else r = v[Q_W-1:0];
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] smul(input logic signed [MUL_W-1:0] a,
                                                    input logic signed [MUL_W-1:0] b);
    logic signed [2*MUL_W-1:0] p;
    p = a * b;
    return p[PROD_W-1:0];
  endfunction

endpackage

[src/hrd_ram.sv]
module hrd_ram #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/hrd_isqrt.sv]
module hrd_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hrd_pkg::PROD_W-1:0]    radicand,
  output logic                          done,
  output logic [hrd_pkg::SQ_STEPS-1:0]  root
);

  logic                             busy;
  logic [hrd_pkg::SQ_CNT_W-1:0]     cnt;
  logic [hrd_pkg::PROD_W-1:0]       v;
  logic [hrd_pkg::SQ_STEPS+2:0]     rem;
  logic [hrd_pkg::SQ_STEPS+2:0]     rem2;
  logic [hrd_pkg::SQ_STEPS+2:0]     trial;

  // two radicand bits per step
  assign rem2  = {rem[hrd_pkg::SQ_STEPS:0], v[hrd_pkg::PROD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        v <= v << 2;
        if (rem2 >= trial) begin
          rem  <= rem2 - trial;
          root <= {root[hrd_pkg::SQ_STEPS-2:0], 1'b1};
        end else begin
          rem  <= rem2;
          root <= {root[hrd_pkg::SQ_STEPS-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == hrd_pkg::SQ_CNT_W'(hrd_pkg::SQ_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/hrd_div.sv]
module hrd_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hrd_pkg::DIV_NUM_W-1:0]   num,
  input  logic [hrd_pkg::Q_W-1:0]         den,
  output logic                            done,
  output logic [hrd_pkg::Q_W-1:0]         quot
);

  logic                             busy;
  logic [hrd_pkg::DIV_CNT_W-1:0]    cnt;
  logic [hrd_pkg::DIV_NUM_W-1:0]    n_sh;
  logic [hrd_pkg::DIV_NUM_W-1:0]    q;
  logic [hrd_pkg::Q_W-1:0]          d;
  logic [hrd_pkg::Q_W-1:0]          rem;
  logic [hrd_pkg::Q_W:0]            rem2;

  assign rem2 = {rem, n_sh[hrd_pkg::DIV_NUM_W-1]};
  assign quot = q[hrd_pkg::Q_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        n_sh <= num;
        d    <= den;
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        n_sh <= n_sh << 1;
        if (rem2 >= {1'b0, d}) begin
          rem <= hrd_pkg::Q_W'(rem2 - {1'b0, d});
          q   <= {q[hrd_pkg::DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem2[hrd_pkg::Q_W-1:0];
          q   <= {q[hrd_pkg::DIV_NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == hrd_pkg::DIV_CNT_W'(hrd_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/primal_dual_huber_rof_denoise_unit.sv]
// primal-dual huber-rof denoiser. a WIDTH x HEIGHT image (q0.16) is streamed in
// raster order with tuser low; loads are taken back to back while idle. the load at
// the last pixel starts a run: a copy pass (a read and a write per pixel) seeds the
// primal and extrapolated images from the noisy one and clears the dual field, then
// num_steps iterations follow, each a dual sweep (paced by the bit-serial square
// root, and by the two bit-serial divisions where the dual vector leaves the unit
// disk) and a primal sweep (paced by the neighbour reads of the dual memories and
// the chain of multiplies). no request is taken during a run. a request with tuser
// high fetches the next result pixel from the primal memory, saturated to 0..1,
// with tlast on the last pixel, and a further request is taken while a result
// waits on the master side. loads and fetches share one pixel counter.
// configuration writes are always taken and must only be made while idle
module primal_dual_huber_rof_denoise_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // pixel
  input  logic                              s_axis_tuser,   // op
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // result_pixel
  output logic                              m_axis_tlast,   // last
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hrd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned AW = hrd_pkg::ADDR_W;
  localparam int unsigned QW = hrd_pkg::Q_W;
  localparam int unsigned PW = hrd_pkg::PROD_W;
  localparam int unsigned MW = hrd_pkg::MUL_W;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH, S_I0, S_I1,
    S_D0, S_D1, S_D2, S_D3, S_DM1, S_DA1, S_DM2, S_DA2, S_DSQ, S_DSQS, S_DSQW,
    S_DDV1, S_DDV1W, S_DDV2, S_DDV2W, S_DWR,
    S_P0, S_P1, S_P2, S_PM1, S_PA1, S_PM2, S_PA2, S_PM3, S_PWR
  } state_t;

  state_t st;

  // configuration registers
  logic [9:0]  num_steps;
  logic [17:0] tau;
  logic [17:0] sigma;
  logic [16:0] theta;
  logic [16:0] dual_scale;
  logic [23:0] tau_gamma;
  logic [16:0] primal_scale;

  // counters
  logic [AW-1:0]               pixel_index;
  logic [AW-1:0]               fetch_addr;
  logic                        fetch_last;
  logic [AW-1:0]               i;
  logic [hrd_pkg::ROW_W-1:0]   r;
  logic [hrd_pkg::COL_W-1:0]   c;
  logic [9:0]                  iteration_count;

  // datapath registers
  logic signed [QW-1:0]  x0, xd, xr, pvo, pho, pv, ph, xo, xn, pvc, phc;
  logic [15:0]           g;
  logic signed [27:0]    sv, sh;
  logic signed [25:0]    dvg;
  logic signed [30:0]    sum;
  logic signed [PW-1:0]  pa, pb;

  // result register
  logic                  m_valid;
  logic [15:0]           m_data;
  logic                  m_last;

  // memory ports
  logic [15:0]    noisy_rd;
  logic [QW-1:0]  primal_rd, xbar_rd, pv_rd, ph_rd;
  logic [AW-1:0]  primal_ra, xbar_ra, pv_ra, ph_ra;
  logic           noisy_we, primal_we, xbar_we, pv_we, ph_we;
  logic [QW-1:0]  seed, xn_w, xb_w, pv_w, ph_w;

  // iterative units
  logic                              sq_start, sq_done;
  logic [hrd_pkg::SQ_STEPS-1:0]      sq_root;
  logic                              dv_start, dv_done;
  logic [hrd_pkg::DIV_NUM_W-1:0]     dv_num;
  logic [QW-1:0]                     dv_quot;
  logic [QW-1:0]                     mag;
  logic                              too_long;

  logic                  accept, at_end, last_pix, last_row, last_col;
  logic signed [24:0]    dv_c, dh_c;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign at_end    = (pixel_index == AW'(hrd_pkg::NPIX - 1));
  assign last_pix  = (i == AW'(hrd_pkg::NPIX - 1));
  assign last_row  = (r == hrd_pkg::ROW_W'(hrd_pkg::HEIGHT - 1));
  assign last_col  = (c == hrd_pkg::COL_W'(hrd_pkg::WIDTH - 1));

  assign s_axis_tready = (st == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tlast  = m_last;

  // forward differences, zero on the last row and column
  assign dv_c = last_row ? '0 : 25'(xd) - 25'(x0);
  assign dh_c = last_col ? '0 : 25'(xr) - 25'(x0);

  // read addresses
  always_comb begin
    case (st)
      S_IDLE:  primal_ra = pixel_index;
      S_FETCH: primal_ra = fetch_addr;
      default: primal_ra = i;
    endcase
    case (st)
      S_D1:    xbar_ra = i + AW'(hrd_pkg::WIDTH);
      S_D2:    xbar_ra = i + AW'(1);
      default: xbar_ra = i;
    endcase
    pv_ra = (st == S_P1) ? i - AW'(hrd_pkg::WIDTH) : i;
    ph_ra = (st == S_P1) ? i - AW'(1) : i;
  end

  // writes
  assign seed      = {{(QW-16){1'b0}}, noisy_rd};
  assign noisy_we  = accept && (s_axis_tuser == hrd_pkg::OP_LOAD);
  assign primal_we = (st == S_I1) || (st == S_PWR);
  assign xbar_we   = primal_we;
  assign pv_we     = (st == S_I1) || (st == S_DWR);
  assign ph_we     = pv_we;
  assign xn_w      = (st == S_I1) ? seed : xn;
  assign xb_w      = (st == S_I1) ? seed : hrd_pkg::sat24(PW'(xn) + hrd_pkg::rnd16(pa));
  assign pv_w      = (st == S_I1) ? '0 : pv;
  assign ph_w      = (st == S_I1) ? '0 : ph;

  // norm and projection
  assign sq_start = (st == S_DSQS);
  assign too_long = (sq_root > hrd_pkg::SQ_STEPS'(65536));
  assign dv_start = (st == S_DDV1) || (st == S_DDV2);
  assign mag      = (st == S_DDV1) ? (pv[QW-1] ? -pv : pv) : (ph[QW-1] ? -ph : ph);
  assign dv_num   = {mag, 16'b0} + hrd_pkg::DIV_NUM_W'(sq_root >> 1);

  hrd_ram #(.DATA_W(16), .DEPTH(hrd_pkg::NPIX)) u_noisy (
    .clk(clk), .we(noisy_we), .waddr(pixel_index), .wdata(s_axis_tdata),
    .raddr(i), .rdata(noisy_rd)
  );
  hrd_ram #(.DATA_W(QW), .DEPTH(hrd_pkg::NPIX)) u_primal (
    .clk(clk), .we(primal_we), .waddr(i), .wdata(xn_w),
    .raddr(primal_ra), .rdata(primal_rd)
  );
  hrd_ram #(.DATA_W(QW), .DEPTH(hrd_pkg::NPIX)) u_xbar (
    .clk(clk), .we(xbar_we), .waddr(i), .wdata(xb_w),
    .raddr(xbar_ra), .rdata(xbar_rd)
  );
  hrd_ram #(.DATA_W(QW), .DEPTH(hrd_pkg::NPIX)) u_pv (
    .clk(clk), .we(pv_we), .waddr(i), .wdata(pv_w),
    .raddr(pv_ra), .rdata(pv_rd)
  );
  hrd_ram #(.DATA_W(QW), .DEPTH(hrd_pkg::NPIX)) u_ph (
    .clk(clk), .we(ph_we), .waddr(i), .wdata(ph_w),
    .raddr(ph_ra), .rdata(ph_rd)
  );

  hrd_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(PW'(pa + pb)),
    .done(sq_done), .root(sq_root)
  );

  hrd_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num),
    .den(QW'(sq_root)), .done(dv_done), .quot(dv_quot)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps    <= 10'd100;
      tau          <= 18'd16384;
      sigma        <= 18'd16384;
      theta        <= 17'd58982;
      dual_scale   <= 17'd65536;
      tau_gamma    <= 24'd65536;
      primal_scale <= 17'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrd_pkg::CFG_NUM_STEPS:    num_steps    <= cfg_data[9:0];
        hrd_pkg::CFG_TAU:          tau          <= cfg_data[17:0];
        hrd_pkg::CFG_SIGMA:        sigma        <= cfg_data[17:0];
        hrd_pkg::CFG_THETA:        theta        <= cfg_data[16:0];
        hrd_pkg::CFG_DUAL_SCALE:   dual_scale   <= cfg_data[16:0];
        hrd_pkg::CFG_TAU_GAMMA:    tau_gamma    <= cfg_data[23:0];
        hrd_pkg::CFG_PRIMAL_SCALE: primal_scale <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // sequencer: one pixel at a time through the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= S_IDLE;
      pixel_index     <= '0;
      iteration_count <= '0;
      i               <= '0;
      r               <= '0;
      c               <= '0;
      m_valid         <= 1'b0;
    end else begin
      // the fetch state loads the result register itself
      if (m_axis_tready && (st != S_FETCH)) begin
        m_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            pixel_index <= at_end ? '0 : pixel_index + 1'b1;
            if (s_axis_tuser == hrd_pkg::OP_FETCH) begin
              fetch_addr <= pixel_index;
              fetch_last <= at_end;
              st         <= S_FETCH;
            end else if (at_end) begin
              // last pixel loaded: seed the run
              i  <= '0;
              r  <= '0;
              c  <= '0;
              iteration_count <= '0;
              st <= S_I0;
            end
          end
        end
        S_FETCH: begin
          if (!m_valid || m_axis_tready) begin
            m_valid <= 1'b1;
            m_last  <= fetch_last;
            if (primal_rd[QW-1]) m_data <= '0;
            else if (|primal_rd[QW-2:16]) m_data <= 16'hFFFF;
            else m_data <= primal_rd[15:0];
            st <= S_IDLE;
          end
        end
        // copy pass
        S_I0: st <= S_I1;
        S_I1: begin
          if (last_pix) begin
            i  <= '0;
            st <= (num_steps == '0) ? S_IDLE : S_D0;
          end else begin
            i  <= i + 1'b1;
            st <= S_I0;
          end
        end
        // dual sweep
        S_D0: st <= S_D1;
        S_D1: begin
          x0  <= $signed(xbar_rd);
          pvo <= $signed(pv_rd);
          pho <= $signed(ph_rd);
          st  <= S_D2;
        end
        S_D2: begin
          xd <= $signed(xbar_rd);
          st <= S_D3;
        end
        S_D3: begin
          xr <= $signed(xbar_rd);
          st <= S_DM1;
        end
        S_DM1: begin
          pa <= hrd_pkg::smul(MW'($signed({1'b0, sigma})), MW'(dv_c));
          pb <= hrd_pkg::smul(MW'($signed({1'b0, sigma})), MW'(dh_c));
          st <= S_DA1;
        end
        S_DA1: begin
          sv <= 28'(PW'(pvo) + hrd_pkg::rnd16(pa));
          sh <= 28'(PW'(pho) + hrd_pkg::rnd16(pb));
          st <= S_DM2;
        end
        S_DM2: begin
          pa <= hrd_pkg::smul(MW'(sv), MW'($signed({1'b0, dual_scale})));
          pb <= hrd_pkg::smul(MW'(sh), MW'($signed({1'b0, dual_scale})));
          st <= S_DA2;
        end
        S_DA2: begin
          pv <= hrd_pkg::sat24(hrd_pkg::rnd16(pa));
          ph <= hrd_pkg::sat24(hrd_pkg::rnd16(pb));
          st <= S_DSQ;
        end
        S_DSQ: begin
          pa <= hrd_pkg::smul(MW'(pv), MW'(pv));
          pb <= hrd_pkg::smul(MW'(ph), MW'(ph));
          st <= S_DSQS;
        end
        S_DSQS: st <= S_DSQW;
        S_DSQW: begin
          if (sq_done) begin
            st <= too_long ? S_DDV1 : S_DWR;
          end
        end
        S_DDV1: st <= S_DDV1W;
        S_DDV1W: begin
          if (dv_done) begin
            pv <= pv[QW-1] ? -dv_quot : dv_quot;
            st <= S_DDV2;
          end
        end
        S_DDV2: st <= S_DDV2W;
        S_DDV2W: begin
          if (dv_done) begin
            ph <= ph[QW-1] ? -dv_quot : dv_quot;
            st <= S_DWR;
          end
        end
        S_DWR: begin
          if (last_pix) begin
            i  <= '0;
            r  <= '0;
            c  <= '0;
            st <= S_P0;
          end else begin
            i  <= i + 1'b1;
            c  <= last_col ? '0 : c + 1'b1;
            r  <= last_col ? r + 1'b1 : r;
            st <= S_D0;
          end
        end
        // primal sweep
        S_P0: st <= S_P1;
        S_P1: begin
          pvc <= $signed(pv_rd);
          phc <= $signed(ph_rd);
          xo  <= $signed(primal_rd);
          g   <= noisy_rd;
          st  <= S_P2;
        end
        S_P2: begin
          // divergence, neighbours outside the image count as zero
          dvg <= 26'(pvc) + 26'(phc)
                 - ((r != '0) ? 26'($signed(pv_rd)) : 26'sd0)
                 - ((c != '0) ? 26'($signed(ph_rd)) : 26'sd0);
          st  <= S_PM1;
        end
        S_PM1: begin
          pa <= hrd_pkg::smul(MW'($signed({1'b0, tau})), MW'(dvg));
          pb <= hrd_pkg::smul(MW'($signed({1'b0, tau_gamma})), MW'($signed({1'b0, g})));
          st <= S_PA1;
        end
        S_PA1: begin
          sum <= 31'(PW'(xo) + hrd_pkg::rnd16(pa) + hrd_pkg::rnd16(pb));
          st  <= S_PM2;
        end
        S_PM2: begin
          pa <= hrd_pkg::smul(MW'(sum), MW'($signed({1'b0, primal_scale})));
          st <= S_PA2;
        end
        S_PA2: begin
          xn <= hrd_pkg::sat24(hrd_pkg::rnd16(pa));
          st <= S_PM3;
        end
        S_PM3: begin
          pa <= hrd_pkg::smul(MW'($signed({1'b0, theta})), MW'(xn) - MW'(xo));
          st <= S_PWR;
        end
        S_PWR: begin
          if (last_pix) begin
            i <= '0;
            r <= '0;
            c <= '0;
            if (iteration_count + 1'b1 == num_steps) begin
              iteration_count <= '0;
              st <= S_IDLE;
            end else begin
              iteration_count <= iteration_count + 1'b1;
              st <= S_D0;
            end
          end else begin
            i  <= i + 1'b1;
            c  <= last_col ? '0 : c + 1'b1;
            r  <= last_col ? r + 1'b1 : r;
            st <= S_P0;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[src/hrd_checker.sv]
module hrd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [15:0]                    m_axis_tdata,
  input logic                           m_axis_tlast
);

  // no result after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a load request makes no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a load");

  // a fetch into an empty output gives its result by way of the fetch state
  a_fetch_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("fetch gave no result");

endmodule

bind primal_dual_huber_rof_denoise_unit hrd_checker u_hrd_checker (.*);

[dv/tb_primal_dual_huber_rof_denoise_unit.sv]
module tb_primal_dual_huber_rof_denoise_unit;

  timeunit 1ns;
  timeprecision 1ps;

  // a full iteration runs a dual and a primal sweep over every pixel, so keep steps low
  localparam longint unsigned CYCLE_LIMIT = 12_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [15:0] result_pixel;
    logic        last;
  } denoised_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // block ports, inputs known from time zero
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // pixel
  logic        s_axis_tuser  = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // result_pixel
  logic        m_axis_tlast;         // last
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [hrd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hrd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  primal_dual_huber_rof_denoise_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // shadow of the block: registers, images, dual field and the pixel counter
  int unsigned steps_q, tau_q, sigma_q, theta_q, dscale_q, tgamma_q, pscale_q;
  int noisy_img [hrd_pkg::NPIX];
  int primal_img [hrd_pkg::NPIX];
  int extrap_img [hrd_pkg::NPIX];
  int dual_v [hrd_pkg::NPIX];
  int dual_h [hrd_pkg::NPIX];
  int unsigned pix_idx;

  denoised_t pending_pixels [$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  int  hold_token = 0;
  longint unsigned cycle_count = 0;

  // q.16 product, nearest with ties upward
  function automatic longint qmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic int sat_q(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // pull a dual component back onto the unit disk, nearest, ties away from zero
  function automatic int shrink_to_disk(int p, longint unsigned n);
    longint unsigned mag, q;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    q = (mag * 65536 + n / 2) / n;
    return (p < 0) ? -int'(q) : int'(q);
  endfunction

  // whole denoising run, started by the load of the last pixel
  function automatic void denoise_image();
    int i, xo, xn, pv, ph;
    longint dv, dh, sv, sh, dvg, acc;
    longint unsigned n;
    for (i = 0; i < hrd_pkg::NPIX; i++) begin
      primal_img[i] = noisy_img[i];
      extrap_img[i] = noisy_img[i];
      dual_v[i] = 0;
      dual_h[i] = 0;
    end
    for (int it = 0; it < int'(steps_q); it++) begin
      // dual ascent and projection
      for (int r = 0; r < hrd_pkg::HEIGHT; r++) begin
        for (int c = 0; c < hrd_pkg::WIDTH; c++) begin
          i = r * hrd_pkg::WIDTH + c;
          dv = 0;
          dh = 0;
          if (r < hrd_pkg::HEIGHT - 1)
            dv = longint'(extrap_img[i + hrd_pkg::WIDTH]) - extrap_img[i];
          if (c < hrd_pkg::WIDTH - 1) dh = longint'(extrap_img[i + 1]) - extrap_img[i];
          sv = dual_v[i] + qmul(sigma_q, dv);
          sh = dual_h[i] + qmul(sigma_q, dh);
          pv = sat_q(qmul(sv, dscale_q));
          ph = sat_q(qmul(sh, dscale_q));
          n = int_sqrt(longint'(pv) * pv + longint'(ph) * ph);
          if (n > 65536) begin
            pv = shrink_to_disk(pv, n);
            ph = shrink_to_disk(ph, n);
          end
          dual_v[i] = pv;
          dual_h[i] = ph;
        end
      end
      // primal step toward the data, then extrapolation
      for (int r = 0; r < hrd_pkg::HEIGHT; r++) begin
        for (int c = 0; c < hrd_pkg::WIDTH; c++) begin
          i = r * hrd_pkg::WIDTH + c;
          dvg = longint'(dual_v[i]) + dual_h[i];
          if (r > 0) dvg = dvg - dual_v[i - hrd_pkg::WIDTH];
          if (c > 0) dvg = dvg - dual_h[i - 1];
          xo = primal_img[i];
          acc = xo + qmul(tau_q, dvg) + qmul(tgamma_q, noisy_img[i]);
          xn = sat_q(qmul(acc, pscale_q));
          primal_img[i] = xn;
          extrap_img[i] = sat_q(xn + qmul(theta_q, longint'(xn) - xo));
        end
      end
    end
  endfunction

  // effect of one accepted request on the shadow state
  function automatic void predict_request(hrd_pkg::op_t op, logic [15:0] pixel);
    int unsigned idx;
    bit at_end;
    int x;
    denoised_t exp_pix;
    idx = pix_idx;
    at_end = (idx == hrd_pkg::NPIX - 1);
    pix_idx = at_end ? 0 : idx + 1;
    if (op == hrd_pkg::OP_LOAD) begin
      noisy_img[idx] = pixel;
      if (at_end) denoise_image();
    end else begin
      x = primal_img[idx];
      if (x < 0) x = 0;
      if (x > 65535) x = 65535;
      exp_pix.result_pixel = x[15:0];
      exp_pix.last = at_end;
      pending_pixels = {pending_pixels, exp_pix};
    end
  endfunction

  function automatic void store_register(hrd_pkg::cfg_idx_t idx, int unsigned val);
    case (idx)
      hrd_pkg::CFG_NUM_STEPS:    steps_q  = val & 32'h3FF;
      hrd_pkg::CFG_TAU:          tau_q    = val & 32'h3FFFF;
      hrd_pkg::CFG_SIGMA:        sigma_q  = val & 32'h3FFFF;
      hrd_pkg::CFG_THETA:        theta_q  = val & 32'h1FFFF;
      hrd_pkg::CFG_DUAL_SCALE:   dscale_q = val & 32'h1FFFF;
      hrd_pkg::CFG_TAU_GAMMA:    tgamma_q = val & 32'hFFFFFF;
      hrd_pkg::CFG_PRIMAL_SCALE: pscale_q = val & 32'h1FFFF;
      default: ;
    endcase
  endfunction

  // one request on the input stream, with an occasional gap ahead of it
  task automatic send_request(hrd_pkg::op_t op, logic [15:0] pixel);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pixel;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(op, pixel);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all results and for the block to be idle before a register write
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || !s_axis_tready) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(hrd_pkg::cfg_idx_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[hrd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mixed loads and fetches up to the end of the image, the final load starting a run
  task automatic mixed_pass();
    hrd_pkg::op_t op;
    while (pix_idx != hrd_pkg::NPIX - 1) begin
      op = ($urandom_range(0, 1) == 0) ? hrd_pkg::OP_LOAD : hrd_pkg::OP_FETCH;
      send_request(op, rand_pixel());
    end
    send_request(hrd_pkg::OP_LOAD, rand_pixel());
  endtask

  task automatic fetch_pixels(int count);
    for (int k = 0; k < count; k++)
      send_request(hrd_pkg::OP_FETCH, 16'($urandom_range(0, 65535)));
  endtask

  // default-like settings with one step; directed extremes at the head of the image,
  // a long receiver hold-off and a full drain while fetching
  task automatic test_single_step_run();
    logic [15:0] heads [12] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
                                16'h0001, 16'hFFFE, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                                16'h0000, 16'h0000};
    write_register(hrd_pkg::CFG_NUM_STEPS, 1);
    write_register(hrd_pkg::CFG_TAU, 16384);
    write_register(hrd_pkg::CFG_SIGMA, 16384);
    write_register(hrd_pkg::CFG_THETA, 58982);
    write_register(hrd_pkg::CFG_DUAL_SCALE, 65536);
    write_register(hrd_pkg::CFG_TAU_GAMMA, 65536);
    write_register(hrd_pkg::CFG_PRIMAL_SCALE, 32768);
    for (int k = 0; k < hrd_pkg::NPIX; k++) begin
      if (k < 12) send_request(hrd_pkg::OP_LOAD, heads[k]);
      else if (k >= hrd_pkg::NPIX - 4) send_request(hrd_pkg::OP_LOAD, 16'hFFFF);
      else send_request(hrd_pkg::OP_LOAD, rand_pixel());
    end
    for (int k = 0; k < 600; k++) begin
      // receiver holds off while requests keep coming, so the input stalls
      if (k == 100) hold_token <= hold_token + 1;
      // sender waits for every outstanding result
      if (k == 400) begin
        stop_sending();
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      send_request(hrd_pkg::OP_FETCH, 16'($urandom_range(0, 65535)));
    end
    stop_sending();
    wait_drained();
  endtask

  // zero steps: the result is the noisy image itself, with other registers at extremes
  task automatic test_zero_steps();
    write_register(hrd_pkg::CFG_NUM_STEPS, 0);
    write_register(hrd_pkg::CFG_TAU, 262143);
    write_register(hrd_pkg::CFG_SIGMA, 0);
    write_register(hrd_pkg::CFG_THETA, 65536);
    write_register(hrd_pkg::CFG_DUAL_SCALE, 0);
    write_register(hrd_pkg::CFG_TAU_GAMMA, 16777215);
    write_register(hrd_pkg::CFG_PRIMAL_SCALE, 0);
    mixed_pass();
    fetch_pixels(400);
    stop_sending();
    wait_drained();
  endtask

  // large steps push the dual field well outside the unit disk
  task automatic test_extreme_step();
    write_register(hrd_pkg::CFG_NUM_STEPS, 1023);
    write_register(hrd_pkg::CFG_NUM_STEPS, 1);
    write_register(hrd_pkg::CFG_TAU, 262143);
    write_register(hrd_pkg::CFG_SIGMA, 262143);
    write_register(hrd_pkg::CFG_THETA, 0);
    write_register(hrd_pkg::CFG_DUAL_SCALE, 65536);
    write_register(hrd_pkg::CFG_TAU_GAMMA, 0);
    write_register(hrd_pkg::CFG_PRIMAL_SCALE, 65536);
    mixed_pass();
    stop_sending();
    // last stretch without idling on either side
    no_idle = 1'b1;
    fetch_pixels(500);
    stop_sending();
  endtask

  // receiver: random stall bursts plus a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    denoised_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel %0d last %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_pixels.pop_front();
        if (want.result_pixel !== m_axis_tdata || want.last !== m_axis_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                     want.result_pixel, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    steps_q = 100; tau_q = 16384; sigma_q = 16384; theta_q = 58982;
    dscale_q = 65536; tgamma_q = 65536; pscale_q = 32768;
    pix_idx = 0;
    for (int i = 0; i < hrd_pkg::NPIX; i++) begin
      noisy_img[i] = 0; primal_img[i] = 0; extrap_img[i] = 0;
      dual_v[i] = 0; dual_h[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_single_step_run();
    test_zero_steps();
    test_extreme_step();
    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
